>>> hdl/spq_pkg.sv
// shared types, constants and codes for the segment proximity query block
package spq_pkg;

  localparam int CW        = 16;
  localparam int OUT_W     = 24;
  localparam int DIST_W    = 10;
  localparam int DX_W      = CW + 1;
  localparam int PROD_W    = 2 * DX_W;
  localparam int FRAC_W    = 8;
  localparam int DIVN_W    = PROD_W + FRAC_W;
  localparam int EVAL_LAT  = 5;
  localparam int MAX_SEG_DEF = 64;

  localparam logic [DIST_W-1:0] LAND_RST = DIST_W'(50);
  localparam logic [DIST_W-1:0] MOVE_RST = DIST_W'(10);

  localparam logic [1:0] FUNC_CLEAR  = 2'd0;
  localparam logic [1:0] FUNC_APPEND = 2'd1;
  localparam logic [1:0] FUNC_QUERY  = 2'd2;

  localparam logic [1:0] MODE_LAND = 2'd0;
  localparam logic [1:0] MODE_MOVE = 2'd1;
  localparam logic [1:0] MODE_DASH = 2'd2;

  localparam logic REG_LAND = 1'b0;
  localparam logic REG_MOVE = 1'b1;

  typedef struct packed {
    logic [1:0]           func;
    logic [1:0]           mode;
    logic signed [CW-1:0] query_x;
    logic signed [CW-1:0] query_y;
    logic signed [CW-1:0] left_x;
    logic signed [CW-1:0] left_y;
    logic signed [CW-1:0] right_x;
    logic signed [CW-1:0] right_y;
    logic                 solid_option;
  } in_t;

  typedef struct packed {
    logic                    hit;
    logic signed [OUT_W-1:0] surface_y;
    logic                    table_full;
  } out_t;

  typedef struct packed {
    logic signed [CW-1:0] lx;
    logic signed [CW-1:0] ly;
    logic signed [CW-1:0] rx;
    logic signed [CW-1:0] ry;
    logic                 solid;
  } seg_t;

  typedef struct packed {
    logic                     pass;
    logic                     solid;
    logic signed [CW-1:0]     ly;
    logic signed [PROD_W-1:0] num;
    logic [CW-1:0]            dx;
  } match_t;

endpackage

>>> hdl/segment_proximity_query.sv
// segment proximity query top level: cell ring, test pipeline, divider, control
// clear, append and unused operations: result in the cycle after the transfer
// query: a scan of the whole ring, a pipeline drain and, on a hit, a division;
//   the block takes one item at a time
// the ring rotates once per query and the divider takes one quotient bit per cycle
// reset empties the table and loads thresholds 50 and 10; stored segments are not cleared
module segment_proximity_query #(
  parameter int MAX_SEGMENTS = spq_pkg::MAX_SEG_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  spq_pkg::in_t         in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output spq_pkg::out_t        out_data_o,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [2:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);

  localparam int CW    = spq_pkg::CW;
  localparam int PW    = spq_pkg::PROD_W;
  localparam int NW    = spq_pkg::DIVN_W;
  localparam int OW    = spq_pkg::OUT_W;
  localparam int QW    = OW + 2;
  localparam int CNT_W = $clog2(MAX_SEGMENTS + 1);
  localparam int DRN_W = $clog2(spq_pkg::EVAL_LAT + 1);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SCAN  = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;
  localparam logic [1:0] ST_DIV   = 2'd3;

  logic [1:0]                  state_q;
  logic [CNT_W-1:0]            count_q, scan_q;
  logic [DRN_W-1:0]            drain_q;
  logic [1:0]                  mode_q;
  logic signed [CW-1:0]        px_q, py_q;
  logic [spq_pkg::DIST_W-1:0]  land_q, move_q;
  logic                        found_q, f_solid_q;
  logic signed [CW-1:0]        f_ly_q;
  logic signed [PW-1:0]        f_num_q;
  logic [CW-1:0]               f_dx_q;
  logic                        out_valid_q;
  spq_pkg::out_t               out_data_q;

  logic                        in_acc, app_en, full, cfg_wr;
  spq_pkg::seg_t               cell_seg [MAX_SEGMENTS];
  spq_pkg::seg_t               new_seg;
  spq_pkg::match_t             match;
  logic                        div_start, div_busy, div_done, div_nz;
  logic [NW-1:0]               div_quo, div_num;
  logic                        neg;
  logic [PW-1:0]               nmag;
  logic signed [QW-1:0]        qm, qs, ly256;
  logic                        hit_ok;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign prdata = {{(32 - spq_pkg::DIST_W){1'b0}}, (paddr[2] == spq_pkg::REG_MOVE) ? move_q : land_q};

  assign in_stall_o = (state_q != ST_IDLE) || out_valid_q;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign full       = (count_q == CNT_W'(MAX_SEGMENTS));
  assign app_en     = in_acc && (in_data_i.func == spq_pkg::FUNC_APPEND) && !full;

  assign new_seg.lx    = in_data_i.left_x;
  assign new_seg.ly    = in_data_i.left_y;
  assign new_seg.rx    = in_data_i.right_x;
  assign new_seg.ry    = in_data_i.right_y;
  assign new_seg.solid = in_data_i.solid_option;

  for (genvar j = 0; j < MAX_SEGMENTS; j++) begin : g_cell
    spq_cell u_cell (
      .clk_i      (clk_i),
      .shift_en_i (state_q == ST_SCAN),
      .load_en_i  (app_en && (count_q == CNT_W'(j))),
      .shift_in_i (cell_seg[(j + 1) % MAX_SEGMENTS]),
      .load_i     (new_seg),
      .seg_o      (cell_seg[j])
    );
  end

  spq_eval u_eval (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i ((state_q == ST_SCAN) && (scan_q < count_q)),
    .seg_i   (cell_seg[0]),
    .px_i    (px_q),
    .py_i    (py_q),
    .mode_i  (mode_q),
    .thr_i   ((mode_q == spq_pkg::MODE_MOVE) ? move_q : land_q),
    .match_o (match)
  );

  assign neg     = f_num_q[PW-1];
  assign nmag    = neg ? PW'(-f_num_q) : PW'(f_num_q);
  assign div_num = {nmag, {spq_pkg::FRAC_W{1'b0}}};
  assign hit_ok  = found_q && ((mode_q != spq_pkg::MODE_DASH) || f_solid_q);
  assign div_start = (state_q == ST_DRAIN) && (drain_q == DRN_W'(spq_pkg::EVAL_LAT)) && hit_ok;

  spq_div u_div (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (div_start),
    .num_i    (div_num),
    .den_i    (f_dx_q),
    .busy_o   (div_busy),
    .done_o   (div_done),
    .quo_o    (div_quo),
    .rem_nz_o (div_nz)
  );

  assign qm    = QW'(div_quo[QW-1:0]);
  assign qs    = neg ? -(qm + QW'(div_nz)) : qm;
  assign ly256 = {{(QW - CW - spq_pkg::FRAC_W){f_ly_q[CW-1]}}, f_ly_q,
                  {spq_pkg::FRAC_W{1'b0}}};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      scan_q      <= '0;
      drain_q     <= '0;
      found_q     <= 1'b0;
      land_q      <= spq_pkg::LAND_RST;
      move_q      <= spq_pkg::MOVE_RST;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_wr) begin
        unique case (paddr[2])
          spq_pkg::REG_LAND: land_q <= pwdata[spq_pkg::DIST_W-1:0];
          spq_pkg::REG_MOVE: move_q <= pwdata[spq_pkg::DIST_W-1:0];
          default: ;
        endcase
      end
      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (match.pass && !found_q) begin
        found_q <= 1'b1;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            unique case (in_data_i.func)
              spq_pkg::FUNC_CLEAR: begin
                count_q     <= '0;
                out_valid_q <= 1'b1;
              end
              spq_pkg::FUNC_APPEND: begin
                if (!full) begin
                  count_q <= count_q + 1'b1;
                end
                out_valid_q <= 1'b1;
              end
              spq_pkg::FUNC_QUERY: begin
                found_q <= 1'b0;
                scan_q  <= '0;
                state_q <= ST_SCAN;
              end
              default: out_valid_q <= 1'b1;
            endcase
          end
        end
        ST_SCAN: begin
          scan_q <= scan_q + 1'b1;
          if (scan_q == CNT_W'(MAX_SEGMENTS - 1)) begin
            drain_q <= '0;
            state_q <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          drain_q <= drain_q + 1'b1;
          if (drain_q == DRN_W'(spq_pkg::EVAL_LAT)) begin
            if (hit_ok) begin
              state_q <= ST_DIV;
            end else begin
              out_valid_q <= 1'b1;
              state_q     <= ST_IDLE;
            end
          end
        end
        ST_DIV: begin
          if (div_done) begin
            out_valid_q <= 1'b1;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      mode_q <= in_data_i.mode;
      px_q   <= in_data_i.query_x;
      py_q   <= in_data_i.query_y;
    end
    if (match.pass && !found_q) begin
      f_solid_q <= match.solid;
      f_ly_q    <= match.ly;
      f_num_q   <= match.num;
      f_dx_q    <= match.dx;
    end
    if (state_q == ST_IDLE && in_acc) begin
      out_data_q.hit        <= 1'b0;
      out_data_q.surface_y  <= '0;
      out_data_q.table_full <= (in_data_i.func == spq_pkg::FUNC_APPEND) && full;
    end else if (state_q == ST_DRAIN) begin
      out_data_q.hit        <= 1'b0;
      out_data_q.surface_y  <= '0;
      out_data_q.table_full <= 1'b0;
    end else if (state_q == ST_DIV && div_done) begin
      out_data_q.hit        <= 1'b1;
      out_data_q.surface_y  <= OW'(ly256 + qs);
      out_data_q.table_full <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  a_full_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_data_q.table_full |-> full)
    else $error("table_full reported while table has room");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(MAX_SEGMENTS))
    else $error("segment count past table size");

  a_div_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_busy |-> state_q == ST_DIV)
    else $error("divider busy outside division state");

  a_hit_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_data_q.hit |-> mode_q == spq_pkg::MODE_LAND ||
      mode_q == spq_pkg::MODE_MOVE || mode_q == spq_pkg::MODE_DASH)
    else $error("hit reported for an unused query mode");

endmodule

>>> hdl/spq_cell.sv
// one table cell of the segment ring
module spq_cell (
  input  logic          clk_i,
  input  logic          shift_en_i,
  input  logic          load_en_i,
  input  spq_pkg::seg_t shift_in_i,
  input  spq_pkg::seg_t load_i,
  output spq_pkg::seg_t seg_o
);

  spq_pkg::seg_t seg_q;

  always_ff @(posedge clk_i) begin
    if (load_en_i) begin
      seg_q <= load_i;
    end else if (shift_en_i) begin
      seg_q <= shift_in_i;
    end
  end

  assign seg_o = seg_q;

endmodule

>>> hdl/spq_eval.sv
// pipelined span, side and distance test of one segment per cycle
module spq_eval (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          valid_i,
  input  spq_pkg::seg_t                 seg_i,
  input  logic signed [spq_pkg::CW-1:0] px_i,
  input  logic signed [spq_pkg::CW-1:0] py_i,
  input  logic [1:0]                    mode_i,
  input  logic [spq_pkg::DIST_W-1:0]    thr_i,
  output spq_pkg::match_t               match_o
);

  localparam int CW  = spq_pkg::CW;
  localparam int DW  = spq_pkg::DX_W;
  localparam int PW  = spq_pkg::PROD_W;
  localparam int AW  = PW + 1;
  localparam int TW  = 2 * spq_pkg::DIST_W;
  localparam int T2W = TW + PW;
  localparam int K   = T2W / 2;
  localparam int VW  = 2 * PW;

  // stage 1
  logic                 s1_v_q, s1_span_q, s1_solid_q;
  logic signed [DW-1:0] s1_dx_q, s1_dy_q, s1_vx_q, s1_vy_q;
  logic signed [CW-1:0] s1_ly_q;
  logic [TW-1:0]        s1_thr2_q;
  logic signed [DW-1:0] dx_d, dy_d, vx_d, vy_d;

  assign dx_d = {seg_i.rx[CW-1], seg_i.rx} - {seg_i.lx[CW-1], seg_i.lx};
  assign dy_d = {seg_i.ry[CW-1], seg_i.ry} - {seg_i.ly[CW-1], seg_i.ly};
  assign vx_d = {px_i[CW-1], px_i} - {seg_i.lx[CW-1], seg_i.lx};
  assign vy_d = {py_i[CW-1], py_i} - {seg_i.ly[CW-1], seg_i.ly};

  // stage 2
  logic                 s2_v_q, s2_span_q, s2_solid_q;
  logic signed [PW-1:0] s2_p1_q, s2_p2_q, s2_dxx_q, s2_dyy_q, s2_vxx_q, s2_vyy_q, s2_num_q;
  logic signed [CW-1:0] s2_ly_q;
  logic [TW-1:0]        s2_thr2_q;
  logic [CW-1:0]        s2_dx_q;

  // stage 3
  logic                 s3_v_q, s3_span_q, s3_solid_q, s3_neg_q;
  logic [AW-1:0]        s3_ad_q;
  logic [PW-1:0]        s3_nn_q, s3_vv_q;
  logic signed [PW-1:0] s3_num_q;
  logic signed [CW-1:0] s3_ly_q;
  logic [TW-1:0]        s3_thr2_q;
  logic [CW-1:0]        s3_dx_q;
  logic signed [AW-1:0] d_d;

  assign d_d = {s2_p1_q[PW-1], s2_p1_q} - {s2_p2_q[PW-1], s2_p2_q};

  // stage 4
  logic                 s4_v_q, s4_span_q, s4_solid_q, s4_neg_q, s4_small_q;
  logic [2*K-1:0]       s4_ad2_q;
  logic [T2W-1:0]       s4_tn_q;
  logic [VW-1:0]        s4_vn_q;
  logic signed [PW-1:0] s4_num_q;
  logic signed [CW-1:0] s4_ly_q;
  logic [CW-1:0]        s4_dx_q;

  // stage 5
  logic [VW-1:0]        lhs_d;
  logic                 side_ok_d, dist_ok_d;
  logic                 pass_q, m_solid_q;
  logic signed [CW-1:0] m_ly_q;
  logic signed [PW-1:0] m_num_q;
  logic [CW-1:0]        m_dx_q;

  assign lhs_d = (VW'(s4_ad2_q) << 8) + (VW'(s4_ad2_q) << 7) + (VW'(s4_ad2_q) << 4);
  assign dist_ok_d = s4_small_q && (T2W'(s4_ad2_q) < s4_tn_q);

  always_comb begin
    unique case (mode_i)
      spq_pkg::MODE_LAND: side_ok_d = !s4_neg_q || (lhs_d < s4_vn_q);
      spq_pkg::MODE_MOVE: side_ok_d = 1'b1;
      spq_pkg::MODE_DASH: side_ok_d = s4_neg_q;
      default:            side_ok_d = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
      s3_v_q <= 1'b0;
      s4_v_q <= 1'b0;
      pass_q <= 1'b0;
    end else begin
      s1_v_q <= valid_i;
      s2_v_q <= s1_v_q;
      s3_v_q <= s2_v_q;
      s4_v_q <= s3_v_q;
      pass_q <= s4_v_q && s4_span_q && side_ok_d && dist_ok_d;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_span_q  <= (dx_d > 0) && (px_i >= seg_i.lx) && (px_i <= seg_i.rx);
    s1_solid_q <= seg_i.solid;
    s1_dx_q    <= dx_d;
    s1_dy_q    <= dy_d;
    s1_vx_q    <= vx_d;
    s1_vy_q    <= vy_d;
    s1_ly_q    <= seg_i.ly;
    s1_thr2_q  <= TW'(thr_i) * TW'(thr_i);

    s2_span_q  <= s1_span_q;
    s2_solid_q <= s1_solid_q;
    s2_p1_q    <= PW'(s1_vx_q) * PW'(s1_dy_q);
    s2_p2_q    <= PW'(s1_vy_q) * PW'(s1_dx_q);
    s2_dxx_q   <= PW'(s1_dx_q) * PW'(s1_dx_q);
    s2_dyy_q   <= PW'(s1_dy_q) * PW'(s1_dy_q);
    s2_vxx_q   <= PW'(s1_vx_q) * PW'(s1_vx_q);
    s2_vyy_q   <= PW'(s1_vy_q) * PW'(s1_vy_q);
    s2_num_q   <= PW'(s1_dy_q) * PW'(s1_vx_q);
    s2_ly_q    <= s1_ly_q;
    s2_thr2_q  <= s1_thr2_q;
    s2_dx_q    <= s1_dx_q[CW-1:0];

    s3_span_q  <= s2_span_q;
    s3_solid_q <= s2_solid_q;
    s3_neg_q   <= d_d[AW-1];
    s3_ad_q    <= d_d[AW-1] ? AW'(-d_d) : AW'(d_d);
    s3_nn_q    <= PW'(s2_dxx_q) + PW'(s2_dyy_q);
    s3_vv_q    <= PW'(s2_vxx_q) + PW'(s2_vyy_q);
    s3_num_q   <= s2_num_q;
    s3_ly_q    <= s2_ly_q;
    s3_thr2_q  <= s2_thr2_q;
    s3_dx_q    <= s2_dx_q;

    s4_span_q  <= s3_span_q;
    s4_solid_q <= s3_solid_q;
    s4_neg_q   <= s3_neg_q;
    s4_small_q <= (s3_ad_q[AW-1:K] == '0);
    s4_ad2_q   <= (2*K)'(s3_ad_q[K-1:0]) * (2*K)'(s3_ad_q[K-1:0]);
    s4_tn_q    <= T2W'(s3_thr2_q) * T2W'(s3_nn_q);
    s4_vn_q    <= VW'(s3_vv_q) * VW'(s3_nn_q);
    s4_num_q   <= s3_num_q;
    s4_ly_q    <= s3_ly_q;
    s4_dx_q    <= s3_dx_q;

    m_solid_q <= s4_solid_q;
    m_ly_q    <= s4_ly_q;
    m_num_q   <= s4_num_q;
    m_dx_q    <= s4_dx_q;
  end

  assign match_o = '{pass: pass_q, solid: m_solid_q, ly: m_ly_q, num: m_num_q, dx: m_dx_q};

endmodule

>>> hdl/spq_div.sv
// restoring divider, one quotient bit per cycle
module spq_div (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  logic [spq_pkg::DIVN_W-1:0]      num_i,
  input  logic [spq_pkg::CW-1:0]          den_i,
  output logic                            busy_o,
  output logic                            done_o,
  output logic [spq_pkg::DIVN_W-1:0]      quo_o,
  output logic                            rem_nz_o
);

  localparam int N  = spq_pkg::DIVN_W;
  localparam int DN = spq_pkg::CW;
  localparam int CN = $clog2(N + 1);

  logic [N-1:0]  quo_q;
  logic [DN-1:0] rem_q, den_q;
  logic [CN-1:0] cnt_q;
  logic          busy_q, done_q;
  logic [DN:0]   t_d;
  logic          ge_d;

  assign t_d  = {rem_q, quo_q[N-1]};
  assign ge_d = (t_d >= {1'b0, den_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CN'(N - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= num_i;
      rem_q <= '0;
      den_q <= den_i;
    end else if (busy_q) begin
      quo_q <= {quo_q[N-2:0], ge_d};
      rem_q <= ge_d ? DN'(t_d - {1'b0, den_q}) : t_d[DN-1:0];
    end
  end

  assign busy_o   = busy_q;
  assign done_o   = done_q;
  assign quo_o    = quo_q;
  assign rem_nz_o = (rem_q != '0);

endmodule

>>> test/testbench.sv
// self-checking testbench for the segment proximity query block
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NSEG = spq_pkg::MAX_SEG_DEF;
  localparam int IN_W = $bits(spq_pkg::in_t);
  localparam longint CYCLE_LIMIT = 1200000;
  localparam logic [1:0] FUNC_UNUSED = 2'd3;
  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam logic [2:0] ADDR_LAND = {spq_pkg::REG_LAND, 2'b00};
  localparam logic [2:0] ADDR_MOVE = {spq_pkg::REG_MOVE, 2'b00};

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  spq_pkg::in_t in_data_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  spq_pkg::out_t out_data_o;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  segment_proximity_query DUT (.*);

  spq_pkg::in_t pending_items[$];
  spq_pkg::out_t expected_results[$];
  spq_pkg::seg_t seg_table[NSEG];
  int unsigned seg_count;
  logic [9:0] land_thr, move_thr;
  int errors = 0;
  longint cycles = 0;
  int gap_left = 0;
  int stall_left = 0;
  bit in_taken = 1'b0;

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("segment_proximity_query verification failed");
      $finish;
    end
  end

  // exact a*b < c*d on nonnegative values
  function automatic bit prod_lt(logic [127:0] a, logic [127:0] b,
                                 logic [127:0] c, logic [127:0] d);
    return (a * b) < (c * d);
  endfunction

  function automatic spq_pkg::out_t surface_lookup(logic [1:0] mode, longint px, longint py);
    spq_pkg::out_t r;
    longint lx, ly, rx, ry, dx, dy, vx, vy, d, ad, nn, vv, thr, num, q, y;
    r = '0;
    if (mode > spq_pkg::MODE_DASH) return r;
    thr = (mode == spq_pkg::MODE_MOVE) ? move_thr : land_thr;
    for (int i = 0; i < seg_count; i++) begin
      lx = seg_table[i].lx; ly = seg_table[i].ly;
      rx = seg_table[i].rx; ry = seg_table[i].ry;
      dx = rx - lx; dy = ry - ly; vx = px - lx; vy = py - ly;
      if (dx <= 0 || px < lx || px > rx) continue;
      d = vx * dy - vy * dx;
      ad = d < 0 ? -d : d;
      nn = dx * dx + dy * dy;
      if (mode == spq_pkg::MODE_LAND && d < 0) begin
        vv = vx * vx + vy * vy;
        if (!prod_lt(400 * ad, ad, vv, nn)) continue;
      end
      if (mode == spq_pkg::MODE_DASH && d >= 0) continue;
      if (!prod_lt(ad, ad, thr * thr, nn)) continue;
      if (mode == spq_pkg::MODE_DASH && !seg_table[i].solid) return r;
      num = dy * vx * 256;
      q = num / dx;
      if (num % dx != 0 && num < 0) q -= 1;
      y = ly * 256 + q;
      r.hit = 1'b1;
      r.surface_y = y[spq_pkg::OUT_W-1:0];
      return r;
    end
    return r;
  endfunction

  function automatic spq_pkg::out_t apply_item(spq_pkg::in_t it);
    spq_pkg::out_t r;
    r = '0;
    unique case (it.func)
      spq_pkg::FUNC_CLEAR: seg_count = 0;
      spq_pkg::FUNC_APPEND: begin
        if (seg_count >= NSEG) r.table_full = 1'b1;
        else begin
          seg_table[seg_count] = '{it.left_x, it.left_y, it.right_x, it.right_y,
                                   it.solid_option};
          seg_count++;
        end
      end
      spq_pkg::FUNC_QUERY: r = surface_lookup(it.mode, it.query_x, it.query_y);
      default: ;
    endcase
    return r;
  endfunction

  task automatic queue_item(spq_pkg::in_t it);
    pending_items = {pending_items, it};
  endtask

  // driver
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (in_taken || !in_valid_i) begin
        if (in_taken) begin
          in_taken = 1'b0;
          gap_left = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 14);
        end
        if (gap_left > 0) begin
          gap_left--;
          in_valid_i <= 1'b0;
        end else if (pending_items.size() > 0) begin
          in_data_i <= pending_items.pop_front();
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_stall_i <= 1'b1;
      end else out_stall_i <= 1'b0;
    end
  end

  // predict at the accepting edge
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && !in_stall_o) begin
      expected_results = {expected_results, apply_item(in_data_i)};
      in_taken = 1'b1;
    end
  end

  // monitor
  always @(posedge clk_i) begin
    spq_pkg::out_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      stall_left = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(0, 14);
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected transfer %p", $time, out_data_o);
        errors++;
      end else begin
        e = expected_results.pop_front();
        if (e.hit !== out_data_o.hit)
          $display("%0t: hit expected %0b actual %0b", $time, e.hit, out_data_o.hit);
        if (e.surface_y !== out_data_o.surface_y)
          $display("%0t: surface_y expected %0d actual %0d", $time, e.surface_y,
                   out_data_o.surface_y);
        if (e.table_full !== out_data_o.table_full)
          $display("%0t: table_full expected %0b actual %0b", $time, e.table_full,
                   out_data_o.table_full);
        if (e !== out_data_o) errors++;
      end
    end
  end

  task automatic reg_write(logic [2:0] addr, logic [31:0] val);
    @(negedge clk_i);
    psel <= 1'b1; pwrite <= 1'b1; paddr <= addr; pwdata <= val;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    if (addr == ADDR_LAND) land_thr = val[9:0];
    else move_thr = val[9:0];
    @(negedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  task automatic wait_drained();
    while (pending_items.size() > 0 || in_valid_i || expected_results.size() > 0)
      @(posedge clk_i);
    repeat (120) @(posedge clk_i);
  endtask

  function automatic logic [15:0] rnd16();
    case ($urandom_range(0, 5))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'($urandom);
      default: return 16'($signed($urandom_range(0, 400)) - 200);
    endcase
  endfunction

  function automatic spq_pkg::in_t mk_append(int lx, int ly, int rx, int ry, bit solid);
    spq_pkg::in_t it;
    it = '0;
    it.func = spq_pkg::FUNC_APPEND;
    it.left_x = 16'(lx); it.left_y = 16'(ly); it.right_x = 16'(rx); it.right_y = 16'(ry);
    it.solid_option = solid;
    it.mode = 2'($urandom); it.query_x = 16'($urandom); it.query_y = 16'($urandom);
    return it;
  endfunction

  function automatic spq_pkg::in_t mk_query(logic [1:0] mode, int qx, int qy);
    spq_pkg::in_t it;
    it = IN_W'({$urandom, $urandom, $urandom, $urandom, $urandom});
    it.func = spq_pkg::FUNC_QUERY; it.mode = mode; it.query_x = 16'(qx); it.query_y = 16'(qy);
    return it;
  endfunction

  function automatic spq_pkg::in_t mk_clear();
    spq_pkg::in_t it;
    it = IN_W'({$urandom, $urandom, $urandom, $urandom, $urandom});
    it.func = spq_pkg::FUNC_CLEAR;
    return it;
  endfunction

  // random appends, clears and unused items, and random queries near the segments
  task automatic random_phase(int n);
    spq_pkg::in_t it;
    int k, sx, sy, ex, ey;
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(0, 99);
      if (k < 4) queue_item(mk_clear());
      else if (k < 30) begin
        sx = $urandom_range(0, 7) == 0 ? $signed(rnd16()) : int'($urandom_range(0, 600)) - 300;
        sy = int'($urandom_range(0, 600)) - 300;
        ex = sx + int'($urandom_range(0, 200)) - 10;
        ey = sy + int'($urandom_range(0, 200)) - 100;
        if ($urandom_range(0, 9) == 0) begin sx = $signed(rnd16()); ey = $signed(rnd16()); end
        queue_item(mk_append(sx, sy, ex, ey, 1'($urandom_range(0, 1))));
      end else if (k < 33) begin
        it = IN_W'({$urandom, $urandom, $urandom, $urandom, $urandom});
        it.func = FUNC_UNUSED;
        queue_item(it);
      end else begin
        it = mk_query(2'($urandom_range(0, 9) == 0 ? MODE_UNUSED : $urandom_range(0, 2)),
                      int'($urandom_range(0, 700)) - 350, int'($urandom_range(0, 700)) - 350);
        if ($urandom_range(0, 9) == 0) begin it.query_x = rnd16(); it.query_y = rnd16(); end
        queue_item(it);
      end
    end
  endtask

  initial begin
    seg_count = 0;
    land_thr = spq_pkg::LAND_RST;
    move_thr = spq_pkg::MOVE_RST;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i) rst_ni <= 1'b1;

    // directed
    queue_item(mk_query(spq_pkg::MODE_LAND, 0, 0));
    queue_item(mk_append(0, 0, 100, 0, 1'b1));
    queue_item(mk_append(0, 0, 0, 50, 1'b1));
    queue_item(mk_append(200, 0, 100, 0, 1'b1));
    queue_item(mk_append(-32768, -32768, 32767, 32767, 1'b0));
    queue_item(mk_append(300, 100, 400, 37, 1'b0));
    queue_item(mk_query(spq_pkg::MODE_LAND, 0, 0));
    queue_item(mk_query(spq_pkg::MODE_LAND, 50, 10));
    queue_item(mk_query(spq_pkg::MODE_LAND, 50, -2));
    queue_item(mk_query(spq_pkg::MODE_LAND, 50, -40));
    queue_item(mk_query(spq_pkg::MODE_MOVE, 50, -9));
    queue_item(mk_query(spq_pkg::MODE_MOVE, 50, 10));
    queue_item(mk_query(spq_pkg::MODE_DASH, 50, -20));
    queue_item(mk_query(spq_pkg::MODE_DASH, 350, 40));
    queue_item(mk_query(MODE_UNUSED, 50, 0));
    queue_item(mk_query(spq_pkg::MODE_MOVE, 333, 79));
    queue_item(mk_query(spq_pkg::MODE_MOVE, 32767, 32767));
    queue_item(mk_query(spq_pkg::MODE_LAND, -32768, -32768));
    queue_item(mk_clear());
    for (int i = 0; i < 66; i++)
      queue_item(mk_append(i, -i, i + 10, i, i[0]));
    queue_item(mk_query(spq_pkg::MODE_DASH, 5, -20));
    wait_drained();

    reg_write(ADDR_LAND, 32'd1023);
    reg_write(ADDR_MOVE, 32'd0);
    random_phase(500);
    wait_drained();
    reg_write(ADDR_LAND, 32'd0);
    reg_write(ADDR_MOVE, 32'hffff_fc00 | 32'd1023);
    random_phase(500);
    wait_drained();
    reg_write(ADDR_LAND, 32'd50);
    reg_write(ADDR_MOVE, 32'd10);
    random_phase(600);
    wait_drained();
    if (errors == 0) $display("segment_proximity_query verification clean");
    else $display("segment_proximity_query verification failed");
    $finish;
  end
endmodule
